### rtl/tclb_pkg.sv
// ----------------------------------------------------------------------------
// tclb_pkg
// Shared types and constants for the text command LED blinker.
// ----------------------------------------------------------------------------
package tclb_pkg;

  localparam int unsigned PeriodW = 32;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgW-1:0] CfgPeriodReset = 16'd100;

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharSp   = 8'h20;
  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // keywords, first character in the lowest byte
  localparam logic [23:0] KwLed   = 24'h64_65_6C;
  localparam logic [15:0] KwOn    = 16'h6E_6F;
  localparam logic [23:0] KwOff   = 24'h66_66_6F;
  localparam logic [39:0] KwBlink = 40'h6B_6E_69_6C_62;

  localparam logic [1:0] ModeOff   = 2'd0;
  localparam logic [1:0] ModeOn    = 2'd1;
  localparam logic [1:0] ModeBlink = 2'd2;

  localparam logic [0:0] ReqChar = 1'b0;
  localparam logic [0:0] ReqTick = 1'b1;

  typedef struct packed {
    logic               set_on;
    logic               set_off;
    logic               set_blink;
    logic [PeriodW-1:0] period;
  } tclb_cmd_t;

endpackage

### rtl/tclb_line_parser.sv
// ----------------------------------------------------------------------------
// tclb_line_parser
// Splits received characters into fields, builds the number of the third
// field and decodes the line on a carriage return.
// ----------------------------------------------------------------------------
module tclb_line_parser import tclb_pkg::*; #(
  parameter int unsigned MAX_FIELD_LEN = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       char_en_i,
  input  logic [7:0] char_i,
  output tclb_cmd_t  cmd_o
);

  localparam int unsigned LenW = $clog2(MAX_FIELD_LEN + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_FIELD_LEN);

  logic [1:0]         field_q, field_d;
  logic [LenW-1:0]    len1_q, len1_d, len2_q, len2_d, len3_q, len3_d;
  logic [2:0][7:0]    word1_q, word1_d;
  logic [4:0][7:0]    word2_q, word2_d;
  logic [PeriodW-1:0] num_q, num_d;
  logic               stop_q, stop_d;

  logic               is_led, is_on, is_off, is_blink;
  logic [PeriodW+3:0] num_mul;
  logic               is_digit;

  assign is_led   = (len1_q == LenW'(3)) && (word1_q == KwLed);
  assign is_on    = (len2_q == LenW'(2)) && (word2_q[1:0] == KwOn);
  assign is_off   = (len2_q == LenW'(3)) && (word2_q[2:0] == KwOff);
  assign is_blink = (len2_q == LenW'(5)) && (word2_q == KwBlink);

  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign num_mul  = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0}
                  + (PeriodW+4)'(char_i - CharZero);

  always_comb begin
    cmd_o.set_on    = 1'b0;
    cmd_o.set_off   = 1'b0;
    cmd_o.set_blink = 1'b0;
    cmd_o.period    = num_q;
    if (char_en_i && (char_i == CharCr) && is_led) begin
      cmd_o.set_on    = is_on;
      cmd_o.set_off   = is_off;
      cmd_o.set_blink = is_blink && (len3_q != '0);
    end
  end

  always_comb begin
    field_d = field_q;
    len1_d  = len1_q;
    len2_d  = len2_q;
    len3_d  = len3_q;
    word1_d = word1_q;
    word2_d = word2_q;
    num_d   = num_q;
    stop_d  = stop_q;
    if (char_en_i) begin
      if (char_i == CharCr) begin
        field_d = '0;
        len1_d  = '0;
        len2_d  = '0;
        len3_d  = '0;
        num_d   = '0;
        stop_d  = 1'b0;
      end else if (char_i == CharSp) begin
        if (field_q != 2'd3) field_d = field_q + 2'd1;
      end else begin
        case (field_q)
          2'd0: begin
            if (len1_q < LenMax) begin
              for (int i = 0; i < 3; i++) begin
                if (len1_q == LenW'(i)) word1_d[i] = char_i;
              end
              len1_d = len1_q + LenW'(1);
            end
          end
          2'd1: begin
            if (len2_q < LenMax) begin
              for (int i = 0; i < 5; i++) begin
                if (len2_q == LenW'(i)) word2_d[i] = char_i;
              end
              len2_d = len2_q + LenW'(1);
            end
          end
          2'd2: begin
            if (len3_q < LenMax) begin
              len3_d = len3_q + LenW'(1);
              if (!stop_q) begin
                if (char_i == CharNul) begin
                  stop_d = 1'b1;
                end else if (is_digit) begin
                  num_d = (num_mul[PeriodW+3:PeriodW] != '0) ? '1 : num_mul[PeriodW-1:0];
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '0;
      len1_q  <= '0;
      len2_q  <= '0;
      len3_q  <= '0;
      num_q   <= '0;
      stop_q  <= 1'b0;
    end else begin
      field_q <= field_d;
      len1_q  <= len1_d;
      len2_q  <= len2_d;
      len3_q  <= len3_d;
      num_q   <= num_d;
      stop_q  <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word1_q <= word1_d;
    word2_q <= word2_d;
  end

endmodule

### rtl/text_command_led_blinker.sv
// ----------------------------------------------------------------------------
// text_command_led_blinker
// Text command LED controller: "led on", "led off", "led blink N".
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group: tuser = 0 carries a received
//   character in tdata, tuser = 1 is a one millisecond tick. Every request
//   yields one result on the m_axis group with the LED level, mode and the
//   held blink period, taken after the request has been applied.
//   cfg_we_i/cfg_wdata_i write the default blink period (reset 100), used
//   when the held period is zero.
//   A request is captured in the input register and applied into the
//   output register when that register is empty or its result is taken.
//   Throughput is one request per cycle while the receiver takes results;
//   the line decode, the multiply by ten and the tick compare all fit in
//   the stage between the two registers. When the receiver stalls, the
//   result holds in the output register and one more request waits in the
//   input register before s_axis_tready_o drops. Reset clears the fields,
//   the LED (off, period 0) and both registers' valid flags.
// ----------------------------------------------------------------------------
module text_command_led_blinker import tclb_pkg::*; #(
  parameter int unsigned MAX_FIELD_LEN = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,   // [7:0] char_code
  input  logic            s_axis_tuser_i,   // [0] req_type
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [39:0]     m_axis_tdata_o,   // [0] led_on, [2:1] led_mode,
                                            // [34:3] blink_period, [39:35] zero
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  logic               in_vld_q, out_vld_q, adv;
  logic               in_type_q;
  logic [7:0]         in_char_q;
  logic [CfgW-1:0]    cfg_q;

  logic [1:0]         mode_q, mode_d;
  logic [PeriodW-1:0] period_q, period_d, per_use;
  logic [PeriodW-1:0] tick_q, tick_d, tick_inc;
  logic               pin_q, pin_d;

  logic               out_led_q;
  logic [1:0]         out_mode_q;
  logic [PeriodW-1:0] out_period_q;

  tclb_cmd_t          cmd;

  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  tclb_line_parser #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_en_i(adv && (in_type_q == ReqChar)),
    .char_i   (in_char_q),
    .cmd_o    (cmd)
  );

  assign per_use  = (period_q == '0) ? PeriodW'(cfg_q) : period_q;
  assign tick_inc = (tick_q == '1) ? tick_q : tick_q + PeriodW'(1);

  always_comb begin
    mode_d   = mode_q;
    period_d = period_q;
    tick_d   = tick_q;
    pin_d    = pin_q;
    if (adv) begin
      if (in_type_q == ReqTick) begin
        unique case (mode_q)
          ModeOff: pin_d = 1'b0;
          ModeOn:  pin_d = 1'b1;
          ModeBlink: begin
            period_d = per_use;
            if (tick_inc >= per_use) begin
              pin_d  = !pin_q;
              tick_d = '0;
            end else begin
              tick_d = tick_inc;
            end
          end
          default: begin
          end
        endcase
      end else if (cmd.set_on) begin
        mode_d = ModeOn;
      end else if (cmd.set_off) begin
        mode_d = ModeOff;
      end else if (cmd.set_blink) begin
        mode_d   = ModeBlink;
        period_d = cmd.period;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cfg_q     <= CfgPeriodReset;
      mode_q    <= ModeOff;
      period_q  <= '0;
      tick_q    <= '0;
      pin_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (adv) out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      mode_q   <= mode_d;
      period_q <= period_d;
      tick_q   <= tick_d;
      pin_q    <= pin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_type_q <= s_axis_tuser_i;
      in_char_q <= s_axis_tdata_i;
    end
    if (adv) begin
      out_led_q    <= pin_d;
      out_mode_q   <= mode_d;
      out_period_q <= period_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b00000, out_period_q, out_mode_q, out_led_q};

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with a free stage");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("applied request lost its result");

  a_off_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_type_q == ReqTick) && (mode_q == ModeOff)) |=> !pin_q)
    else $error("LED lit after tick in off mode");

  a_blink_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_type_q == ReqTick) && (mode_q == ModeBlink) && (cfg_q != '0))
      |=> (period_q != '0))
    else $error("blink tick left a zero period");

endmodule
